// File: rtl/core/pbsf_pkg.sv
package pbsf_pkg;

  // line constants
  localparam logic [7:0] FLAG_BYTE  = 8'h7E;
  localparam logic [7:0] ADDR_BYTE  = 8'hFF;
  localparam logic [7:0] CTRL_BYTE  = 8'h03;
  localparam logic [7:0] ESC_BYTE   = 8'h7D;
  localparam logic [7:0] ESC_XOR    = 8'h20;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] FCS_BYTE   = 8'h00;
  localparam logic [15:0] PROTO_RESET = 16'h0021;

  // descriptor queue between front and back
  localparam int QPTR_W      = 2;
  localparam int QUEUE_DEPTH = 1 << QPTR_W;

  // one classified payload byte
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        final_byte;
    logic        open_frame;
    logic        needs_esc;
    logic [15:0] protocol;
  } desc_t;

  // emit sequencer phases
  typedef enum logic [3:0] {
    PH_START,
    PH_FLAG,
    PH_ADDR,
    PH_CTRL,
    PH_PROT_HI,
    PH_PROT_LO,
    PH_ESC,
    PH_DATA,
    PH_FCS_HI,
    PH_FCS_LO,
    PH_CLOSE
  } phase_t;

endpackage

// File: rtl/core/pbsf_if.sv
// payload byte channel
interface pbsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       final_byte;
  modport source (output valid, output payload_byte, output final_byte, input ready);
  modport sink (input valid, input payload_byte, input final_byte, output ready);
endinterface

// line byte channel
interface pbsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       frame_end;
  modport source (output valid, output line_byte, output frame_end, input ready);
  modport sink (input valid, input line_byte, input frame_end, output ready);
endinterface

// protocol number write channel
interface pbsf_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] protocol_number;
  modport source (output valid, output protocol_number, input ready);
  modport sink (input valid, input protocol_number, output ready);
endinterface

// File: rtl/core/pbsf_front.sv
module pbsf_front import pbsf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  pbsf_in_if.sink          payload,
  pbsf_cfg_if.sink         cfg,
  input  logic             full,
  output logic             push,
  output desc_t            push_desc
);

  logic [15:0] protocol;
  logic        inside_frame;

  assign payload.ready = !full;
  assign cfg.ready     = 1'b1;
  assign push          = payload.valid && !full;

  // protocol register
  always_ff @(posedge clk) begin
    if (rst) begin
      protocol <= PROTO_RESET;
    end else if (cfg.valid) begin
      protocol <= cfg.protocol_number;
    end
  end

  // frame open tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_frame <= 1'b0;
    end else if (push) begin
      inside_frame <= !payload.final_byte;
    end
  end

  // classify the byte
  always_comb begin
    push_desc.payload_byte = payload.payload_byte;
    push_desc.final_byte   = payload.final_byte;
    push_desc.open_frame   = !inside_frame;
    push_desc.needs_esc    = (payload.payload_byte == FLAG_BYTE) ||
                             (payload.payload_byte == ESC_BYTE) ||
                             (payload.payload_byte < CTRL_LIMIT);
    push_desc.protocol     = protocol;
  end

endmodule

// File: rtl/core/pbsf_queue.sv
module pbsf_queue import pbsf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output logic  full,
  output logic  head_valid,
  output desc_t head
);

  desc_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/pbsf_back.sv
module pbsf_back import pbsf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  desc_t     head,
  output logic      pop,
  pbsf_out_if.source line
);

  phase_t     phase;
  phase_t     phase_next;
  phase_t     cur;
  logic       out_valid;
  logic       out_valid_next;
  logic [7:0] out_byte;
  logic       out_end;
  logic [7:0] emit_byte;
  logic       emit_end;
  logic       load;
  logic       emit;

  assign line.valid     = out_valid;
  assign line.line_byte = out_byte;
  assign line.frame_end = out_end;

  assign load = !out_valid || line.ready;
  assign emit = head_valid && load;

  // phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
    end else begin
      phase <= phase_next;
    end
  end

  // sequencer: byte for the current phase and the phase after it
  always_comb begin
    if (phase == PH_START) begin
      if (head.open_frame)     cur = PH_FLAG;
      else if (head.needs_esc) cur = PH_ESC;
      else                     cur = PH_DATA;
    end else begin
      cur = phase;
    end
    emit_end   = 1'b0;
    pop        = 1'b0;
    phase_next = phase;
    emit_byte  = FCS_BYTE;
    case (cur)
      PH_FLAG:    begin emit_byte = FLAG_BYTE;           phase_next = PH_ADDR;    end
      PH_ADDR:    begin emit_byte = ADDR_BYTE;           phase_next = PH_CTRL;    end
      PH_CTRL:    begin emit_byte = CTRL_BYTE;           phase_next = PH_PROT_HI; end
      PH_PROT_HI: begin emit_byte = head.protocol[15:8]; phase_next = PH_PROT_LO; end
      PH_PROT_LO: begin
        emit_byte  = head.protocol[7:0];
        phase_next = head.needs_esc ? PH_ESC : PH_DATA;
      end
      PH_ESC:     begin emit_byte = ESC_BYTE;            phase_next = PH_DATA;    end
      PH_DATA: begin
        emit_byte = head.needs_esc ? (head.payload_byte ^ ESC_XOR) : head.payload_byte;
        if (head.final_byte) begin
          phase_next = PH_FCS_HI;
        end else begin
          phase_next = PH_START;
          pop        = emit;
        end
      end
      PH_FCS_HI:  begin emit_byte = FCS_BYTE;            phase_next = PH_FCS_LO;  end
      PH_FCS_LO:  begin emit_byte = FCS_BYTE;            phase_next = PH_CLOSE;   end
      PH_CLOSE: begin
        emit_byte  = FLAG_BYTE;
        emit_end   = 1'b1;
        phase_next = PH_START;
        pop        = emit;
      end
      default:    begin emit_byte = FCS_BYTE;            phase_next = PH_START;   end
    endcase
    if (!emit) begin
      phase_next = phase;
    end
  end

  // output register
  always_comb begin
    if (emit)            out_valid_next = 1'b1;
    else if (line.ready) out_valid_next = 1'b0;
    else                 out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= emit_byte;
      out_end  <= emit_end;
    end
  end

`ifndef SYNTHESIS
  // mid-item phase only while a descriptor is held
  a_phase_has_head: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_START) |-> head_valid)
    else $error("sequencer mid-item without a queued descriptor");

  // closing mark only on a flag byte
  a_end_on_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_end) |-> (out_byte == FLAG_BYTE))
    else $error("frame_end on a byte other than the flag");

  // escape is always followed by the data phase
  a_esc_then_data: assert property (@(posedge clk) disable iff (rst)
    (emit && cur == PH_ESC) |=> (phase == PH_DATA))
    else $error("escape byte not followed by data byte");
`endif

endmodule

// File: rtl/core/ppp_byte_stuff_framer.sv
// The first line byte of an item passes the descriptor queue and then the output byte
// register before it is valid. One line byte per cycle while line ready stays high; an
// item causes 1 to 10 line bytes, and the single output byte register sets that rate.
// A four-entry descriptor queue lets input accept continue while the output drains.
// Reset (synchronous, active high) closes any open frame, empties the queue, drops
// output valid and sets the protocol number to 0x0021.
module ppp_byte_stuff_framer import pbsf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  pbsf_in_if.sink    payload,
  pbsf_cfg_if.sink   cfg,
  pbsf_out_if.source line
);

  logic  full;
  logic  push;
  desc_t push_desc;
  logic  pop;
  logic  head_valid;
  desc_t head;

  // accept and classify
  pbsf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .payload   (payload),
    .cfg       (cfg),
    .full      (full),
    .push      (push),
    .push_desc (push_desc)
  );

  // descriptor queue
  pbsf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  // emit sequencer
  pbsf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .line       (line)
  );

endmodule

// File: test/tb_top.sv
module tb_top;
  import pbsf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // run limit in cycles, well above the slowest legal run
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 108;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       frame_end;
  } line_item_t;

  logic clk;
  logic rst;

  pbsf_in_if  payload_ch ();
  pbsf_cfg_if cfg_ch ();
  pbsf_out_if line_ch ();

  ppp_byte_stuff_framer dut (
    .clk     (clk),
    .rst     (rst),
    .payload (payload_ch),
    .cfg     (cfg_ch),
    .line    (line_ch)
  );

  // framer model state
  logic [15:0] proto_shadow;
  logic        frame_open;
  line_item_t  expected_line[$];

  int  error_count;
  int  report_count;
  int  cycle_count;
  int  items_sent;
  bit  payload_held;
  bit  src_no_idle;
  bit  sink_no_idle;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // expected line bytes for one accepted payload byte
  function automatic void predict_line_bytes(input logic [7:0] b, input logic fin);
    if (!frame_open) begin
      expected_line.push_back('{FLAG_BYTE, 1'b0});
      expected_line.push_back('{ADDR_BYTE, 1'b0});
      expected_line.push_back('{CTRL_BYTE, 1'b0});
      expected_line.push_back('{proto_shadow[15:8], 1'b0});
      expected_line.push_back('{proto_shadow[7:0], 1'b0});
      frame_open = 1'b1;
    end
    if (b == FLAG_BYTE || b == ESC_BYTE || b < CTRL_LIMIT) begin
      expected_line.push_back('{ESC_BYTE, 1'b0});
      expected_line.push_back('{b ^ ESC_XOR, 1'b0});
    end else begin
      expected_line.push_back('{b, 1'b0});
    end
    if (fin) begin
      expected_line.push_back('{FCS_BYTE, 1'b0});
      expected_line.push_back('{FCS_BYTE, 1'b0});
      expected_line.push_back('{FLAG_BYTE, 1'b1});
      frame_open = 1'b0;
    end
  endfunction

  // compare one line transaction with the oldest expected byte
  function automatic void check_line_byte(input logic [7:0] got_byte, input logic got_end);
    line_item_t exp_item;
    if (expected_line.size() == 0) begin
      error_count++;
      if (report_count < REPORT_MAX) begin
        $display("unexpected line byte %h end=%b", got_byte, got_end);
        report_count++;
      end
      return;
    end
    exp_item = expected_line.pop_front();
    if (got_byte !== exp_item.line_byte || got_end !== exp_item.frame_end) begin
      error_count++;
      if (report_count < REPORT_MAX) begin
        $display("line mismatch: expected %h end=%b, got %h end=%b",
                 exp_item.line_byte, exp_item.frame_end, got_byte, got_end);
        report_count++;
      end
    end
  endfunction

  // line sink with random stalls
  initial begin : line_sink
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = sink_no_idle ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        line_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      line_ch.ready <= 1'b1;
      do @(posedge clk); while (!(line_ch.valid === 1'b1 && line_ch.ready === 1'b1));
      check_line_byte(line_ch.line_byte, line_ch.frame_end);
    end
  end

  // one payload transaction; valid stays high when the next gap is zero
  task automatic send_payload_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = src_no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      if (payload_held) begin
        payload_ch.valid <= 1'b0;
        payload_held = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    payload_ch.valid        <= 1'b1;
    payload_ch.payload_byte <= b;
    payload_ch.final_byte   <= fin;
    payload_held = 1'b1;
    do @(posedge clk); while (payload_ch.ready !== 1'b1);
    predict_line_bytes(b, fin);
    items_sent++;
  endtask

  // hold off input until every expected line byte is out
  task automatic wait_frame_drained();
    if (payload_held) begin
      payload_ch.valid <= 1'b0;
      payload_held = 1'b0;
    end
    while (expected_line.size() != 0) @(posedge clk);
  endtask

  // protocol register write, only with the framer idle
  task automatic write_protocol(input logic [15:0] value);
    cfg_ch.valid           <= 1'b1;
    cfg_ch.protocol_number <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    proto_shadow = value;
  endtask

  // reset value of the protocol field, single-byte frame
  task automatic test_default_header();
    src_no_idle  = 1'b1;
    sink_no_idle = 1'b1;
    send_payload_byte(8'h41, 1'b1);
    wait_frame_drained();
  endtask

  // escape set and its neighbors, payload extremes
  task automatic test_escape_set();
    src_no_idle  = 1'b0;
    sink_no_idle = 1'b0;
    send_payload_byte(FLAG_BYTE, 1'b0);
    send_payload_byte(ESC_BYTE, 1'b0);
    send_payload_byte(8'h00, 1'b0);
    send_payload_byte(8'h1F, 1'b0);
    send_payload_byte(8'h20, 1'b0);
    send_payload_byte(8'hFF, 1'b0);
    send_payload_byte(8'h7C, 1'b0);
    send_payload_byte(8'h7F, 1'b0);
    send_payload_byte(8'h5E, 1'b1);
  endtask

  // escaped byte that both opens and closes a frame
  task automatic test_max_expansion();
    src_no_idle  = 1'b1;
    sink_no_idle = 1'b0;
    send_payload_byte(FLAG_BYTE, 1'b1);
    send_payload_byte(8'h00, 1'b1);
    sink_no_idle = 1'b1;
    send_payload_byte(ESC_BYTE, 1'b1);
    wait_frame_drained();
  endtask

  // header bytes go out raw, even when they look like flag or escape
  task automatic test_header_extremes();
    src_no_idle  = 1'b0;
    sink_no_idle = 1'b0;
    write_protocol(16'h7E7D);
    send_payload_byte(8'h10, 1'b0);
    send_payload_byte(8'hA5, 1'b1);
    wait_frame_drained();
    write_protocol(16'h0000);
    send_payload_byte(8'hFF, 1'b1);
    wait_frame_drained();
    write_protocol(16'hFFFF);
    send_payload_byte(8'h00, 1'b1);
    wait_frame_drained();
    write_protocol(16'h1F03);
    send_payload_byte(8'h21, 1'b1);
    wait_frame_drained();
  endtask

  // write while a frame is open: only the next header changes
  task automatic test_midframe_protocol();
    src_no_idle  = 1'b0;
    sink_no_idle = 1'b0;
    send_payload_byte(8'h33, 1'b0);
    send_payload_byte(8'h7E, 1'b0);
    wait_frame_drained();
    write_protocol(16'hC021);
    send_payload_byte(8'h44, 1'b1);
    send_payload_byte(8'h55, 1'b1);
    wait_frame_drained();
  endtask

  // random frames with mixed content, idle patterns and register writes
  task automatic test_random_frames();
    int start_count;
    int frame_len;
    int pick;
    logic [7:0] b;
    logic [15:0] proto;
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      src_no_idle  = ($urandom_range(0, 3) == 0);
      sink_no_idle = ($urandom_range(0, 3) == 0);
      frame_len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      for (int i = 0; i < frame_len; i++) begin
        case ($urandom_range(0, 7))
          0: b = FLAG_BYTE;
          1: b = ESC_BYTE;
          2: b = 8'($urandom_range(0, 31));
          default: b = 8'($urandom_range(0, 255));
        endcase
        send_payload_byte(b, (i == frame_len - 1));
        // occasional write with a frame open
        if (i != frame_len - 1 && $urandom_range(0, 29) == 0) begin
          wait_frame_drained();
          write_protocol(16'($urandom_range(0, 65535)));
        end
      end
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        wait_frame_drained();
        case ($urandom_range(0, 5))
          0: proto = 16'h0000;
          1: proto = 16'hFFFF;
          2: proto = {FLAG_BYTE, ESC_BYTE};
          default: proto = 16'($urandom_range(0, 65535));
        endcase
        write_protocol(proto);
      end else if (pick == 2) begin
        wait_frame_drained();
      end
    end
  endtask

  // main sequence
  initial begin
    rst                     <= 1'b1;
    payload_ch.valid        <= 1'b0;
    payload_ch.payload_byte <= 8'h00;
    payload_ch.final_byte   <= 1'b0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.protocol_number  <= 16'h0000;
    line_ch.ready           <= 1'b0;
    proto_shadow = PROTO_RESET;
    frame_open   = 1'b0;
    error_count  = 0;
    report_count = 0;
    cycle_count  = 0;
    items_sent   = 0;
    payload_held = 1'b0;
    src_no_idle  = 1'b0;
    sink_no_idle = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_default_header();
    test_escape_set();
    test_max_expansion();
    test_header_extremes();
    test_midframe_protocol();
    test_random_frames();

    // drain and let the pipeline settle
    src_no_idle  = 1'b0;
    sink_no_idle = 1'b0;
    wait_frame_drained();
    repeat (20) @(posedge clk);
    if (expected_line.size() != 0) begin
      error_count++;
      $display("%0d expected line bytes never arrived", expected_line.size());
    end
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// File: ppp_byte_stuff_framer.f
rtl/core/pbsf_pkg.sv
rtl/core/pbsf_if.sv
rtl/core/pbsf_front.sv
rtl/core/pbsf_queue.sv
rtl/core/pbsf_back.sv
rtl/core/ppp_byte_stuff_framer.sv
test/tb_top.sv
